FILE: sv/mhtq_pkg.sv
// ----------------------------------------------------------------------------
// mhtq_pkg
// shared constants and types of the min-heap timer queue
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int CAPACITY    = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ID_W        = 16;
  localparam int EXP_W       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_DEL  = 3'd1;
  localparam logic [2:0] OP_FIRE = 3'd2;
  localparam logic [2:0] OP_ADJ  = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  localparam logic [2:0] K_ADDED    = 3'd0;
  localparam logic [2:0] K_DELETED  = 3'd1;
  localparam logic [2:0] K_ADJUSTED = 3'd2;
  localparam logic [2:0] K_FIRED    = 3'd3;
  localparam logic [2:0] K_NOTFOUND = 3'd4;
  localparam logic [2:0] K_FULL     = 3'd5;
  localparam logic [2:0] K_NONEDUE  = 3'd6;

  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [ID_W-1:0]  id;
  } ent_t;

endpackage

FILE: sv/min_heap_timer_queue_core.sv
// ----------------------------------------------------------------------------
// min_heap_timer_queue_core
// binary min-heap of timers in one entry memory, walked by a sequencer
// add writes the new entry at the end of the heap and sifts it up; delete/fire/adjust
// first search the entries one by one for the id, then sift the moved entry
// tick: fires due timers from the root one at a time, each followed by a sift
// one command at a time while busy is high; results are one-cycle strobes
// synchronous active-low reset empties the heap and clears the id counter
// ----------------------------------------------------------------------------
module min_heap_timer_queue_core
  import mhtq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_opcode,
  input  logic [ID_W-1:0]  in_timer_id_in,
  input  logic [EXP_W-1:0] in_time_amount,
  input  logic [EXP_W-1:0] in_now,
  output logic             out_valid,
  output logic [2:0]       out_result_kind,
  output logic [ID_W-1:0]  out_timer_id_out,
  output logic [EXP_W-1:0] out_expiry_out,
  output logic             out_last
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UP    = 4'd1;
  localparam logic [3:0] S_UPC   = 4'd2;
  localparam logic [3:0] S_DN    = 4'd3;
  localparam logic [3:0] S_DNC   = 4'd4;
  localparam logic [3:0] S_WFIN  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_SCHK  = 4'd7;
  localparam logic [3:0] S_RLAST = 4'd8;
  localparam logic [3:0] S_RLD   = 4'd9;
  localparam logic [3:0] S_TREAD = 4'd10;
  localparam logic [3:0] S_TCHK  = 4'd11;

  logic [3:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0]  idc_r, idc_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  ent_t             mov_r, mov_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [ID_W-1:0]  idin_r, idin_nxt;
  logic [EXP_W-1:0] amt_r, amt_nxt;
  logic [EXP_W-1:0] now_r, now_nxt;
  logic [RES_W-1:0] nres_r, nres_nxt;
  logic             dn_r, dn_nxt;
  logic             two_r, two_nxt;
  logic             moved_r, moved_nxt;
  logic             pend_r, pend_nxt;
  ent_t             pent_r, pent_nxt;

  logic             ov_r, ov_nxt;
  logic [2:0]       ok_r, ok_nxt;
  logic [ID_W-1:0]  oid_r, oid_nxt;
  logic [EXP_W-1:0] oexp_r, oexp_nxt;
  logic             olast_r, olast_nxt;

  logic             we;
  logic [IDX_W-1:0] wa, ra, rb;
  ent_t             wd, qa, qb;

  logic [IDX_W:0]   child, child1;
  logic [IDX_W-1:0] parent;
  logic [EXP_W:0]   sum;
  ent_t             pick;
  logic             pick_b;
  logic [CNT_W-1:0] cnt_dec;

  mhtq_ram #(.DW($bits(ent_t)), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .wa(wa), .wd(wd), .ra(ra), .rb(rb), .qa(qa), .qb(qb)
  );

  assign child   = {pos_r, 1'b1};
  assign child1  = child + 1'b1;
  assign parent  = (pos_r - 1'b1) >> 1;
  assign sum     = {1'b0, in_now} + {1'b0, in_time_amount};
  assign pick_b  = ({1'b0, child1} < {1'b0, cnt_r}) && (qb.expiry < qa.expiry);
  assign pick    = pick_b ? qb : qa;
  assign cnt_dec = cnt_r - 1'b1;

  always_comb begin
    st_nxt = st_r;  cnt_nxt = cnt_r;  idc_nxt = idc_r;  pos_nxt = pos_r;
    k_nxt = k_r;    mov_nxt = mov_r;  op_nxt = op_r;    idin_nxt = idin_r;
    amt_nxt = amt_r; now_nxt = now_r; nres_nxt = nres_r; dn_nxt = dn_r;
    two_nxt = two_r; moved_nxt = moved_r; pend_nxt = pend_r; pent_nxt = pent_r;
    ov_nxt = 1'b0;  ok_nxt = ok_r;  oid_nxt = oid_r;  oexp_nxt = oexp_r;
    olast_nxt = olast_r;
    we = 1'b0;  wa = pos_r;  wd = mov_r;  ra = pos_r;  rb = pos_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_opcode; idin_nxt = in_timer_id_in;
          amt_nxt = in_time_amount; now_nxt = in_now;
          two_nxt = 1'b0; moved_nxt = 1'b0; nres_nxt = '0; pend_nxt = 1'b0;
          k_nxt = '0;
          case (in_opcode)
            OP_ADD: begin
              ov_nxt = 1'b1; olast_nxt = 1'b1;
              if (cnt_r == CNT_W'(CAPACITY)) begin
                ok_nxt = K_FULL; oid_nxt = '0; oexp_nxt = '0;
              end else begin
                idc_nxt = idc_r + 1'b1;
                mov_nxt.expiry = sum[EXP_W] ? '1 : sum[EXP_W-1:0];
                mov_nxt.id = idc_r + 1'b1;
                ok_nxt = K_ADDED; oid_nxt = idc_r + 1'b1;
                oexp_nxt = sum[EXP_W] ? '1 : sum[EXP_W-1:0];
                pos_nxt = cnt_r[IDX_W-1:0];
                cnt_nxt = cnt_r + 1'b1;
                dn_nxt = 1'b0;
                st_nxt = S_UP;
              end
            end
            OP_DEL, OP_FIRE, OP_ADJ: begin
              if (cnt_r == '0) begin
                ov_nxt = 1'b1; olast_nxt = 1'b1; ok_nxt = K_NOTFOUND;
                oid_nxt = in_timer_id_in; oexp_nxt = '0;
              end else begin
                st_nxt = S_SCAN;
              end
            end
            OP_TICK: st_nxt = S_TREAD;
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_UP: begin
        ra = parent;
        st_nxt = (pos_r == '0) ? S_WFIN : S_UPC;
      end
      S_UPC: begin
        if (mov_r.expiry < qa.expiry) begin
          we = 1'b1; wd = qa; pos_nxt = parent; moved_nxt = 1'b1;
          st_nxt = S_UP;
        end else begin
          st_nxt = S_WFIN;
        end
      end
      S_DN: begin
        ra = child[IDX_W-1:0];
        rb = child1[IDX_W-1:0];
        st_nxt = ({1'b0, child} >= {1'b0, cnt_r}) ? S_WFIN : S_DNC;
      end
      S_DNC: begin
        if (mov_r.expiry <= pick.expiry) begin
          st_nxt = S_WFIN;
        end else begin
          we = 1'b1; wd = pick; moved_nxt = 1'b1;
          pos_nxt = pick_b ? child1[IDX_W-1:0] : child[IDX_W-1:0];
          st_nxt = S_DN;
        end
      end
      S_WFIN: begin
        we = 1'b1;
        if (!two_r && ((op_r == OP_ADJ && !dn_r) ||
                       (op_r != OP_ADD && op_r != OP_ADJ && dn_r && !moved_r))) begin
          two_nxt = 1'b1;
          dn_nxt = !dn_r;
          st_nxt = dn_r ? S_UP : S_DN;
        end else begin
          st_nxt = (op_r == OP_TICK) ? S_TREAD : S_IDLE;
        end
      end
      S_SCAN: begin
        ra = k_r;
        st_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (qa.id == idin_r) begin
          pos_nxt = k_r;
          ov_nxt = 1'b1; olast_nxt = 1'b1; oid_nxt = idin_r;
          if (op_r == OP_ADJ) begin
            ok_nxt = K_ADJUSTED; oexp_nxt = amt_r;
            mov_nxt.expiry = amt_r; mov_nxt.id = qa.id;
            dn_nxt = 1'b0;
            st_nxt = S_UP;
          end else begin
            ok_nxt = (op_r == OP_DEL) ? K_DELETED : K_FIRED;
            oexp_nxt = qa.expiry;
            cnt_nxt = cnt_dec;
            st_nxt = ({1'b0, k_r} == cnt_dec) ? S_IDLE : S_RLAST;
          end
        end else if ({1'b0, k_r} + 1'b1 >= cnt_r) begin
          ov_nxt = 1'b1; olast_nxt = 1'b1; ok_nxt = K_NOTFOUND;
          oid_nxt = idin_r; oexp_nxt = '0;
          st_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
          st_nxt = S_SCAN;
        end
      end
      S_RLAST: begin
        ra = cnt_r[IDX_W-1:0];
        st_nxt = S_RLD;
      end
      S_RLD: begin
        mov_nxt = qa; dn_nxt = 1'b1; two_nxt = 1'b0; moved_nxt = 1'b0;
        st_nxt = S_DN;
      end
      S_TREAD: begin
        ra = '0;
        st_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (cnt_r != '0 && nres_r < RES_W'(MAX_RESULTS) && qa.expiry <= now_r) begin
          if (pend_r) begin
            ov_nxt = 1'b1; olast_nxt = 1'b0; ok_nxt = K_FIRED;
            oid_nxt = pent_r.id; oexp_nxt = pent_r.expiry;
          end
          pend_nxt = 1'b1; pent_nxt = qa;
          nres_nxt = nres_r + 1'b1;
          pos_nxt = '0;
          cnt_nxt = cnt_dec;
          st_nxt = (cnt_dec == '0) ? S_TREAD : S_RLAST;
        end else begin
          ov_nxt = 1'b1; olast_nxt = 1'b1;
          ok_nxt = pend_r ? K_FIRED : K_NONEDUE;
          oid_nxt = pend_r ? pent_r.id : '0;
          oexp_nxt = pend_r ? pent_r.expiry : '0;
          pend_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      idc_r <= '0;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      idc_r <= idc_nxt;
      ov_r <= ov_nxt;
      pend_r <= pend_nxt;
    end
    pos_r <= pos_nxt;   k_r <= k_nxt;       mov_r <= mov_nxt;   op_r <= op_nxt;
    idin_r <= idin_nxt; amt_r <= amt_nxt;   now_r <= now_nxt;   nres_r <= nres_nxt;
    dn_r <= dn_nxt;     two_r <= two_nxt;   moved_r <= moved_nxt;
    pent_r <= pent_nxt; ok_r <= ok_nxt;     oid_r <= oid_nxt;   oexp_r <= oexp_nxt;
    olast_r <= olast_nxt;
  end

  assign busy             = (st_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_result_kind  = ok_r;
  assign out_timer_id_out = oid_r;
  assign out_expiry_out   = oexp_r;
  assign out_last         = olast_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("heap count above capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_ADD && cnt_r != CNT_W'(CAPACITY))
      |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("add did not grow heap");

  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == K_FULL || out_result_kind == K_NONEDUE)) |-> out_last)
    else $error("single result without last");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_TICK) |=> busy)
    else $error("tick not started");
`endif

endmodule

FILE: sv/mhtq_ram.sv
// ----------------------------------------------------------------------------
// mhtq_ram
// heap entry memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
module mhtq_ram #(
  parameter int DW    = 48,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra,
  input  logic [AW-1:0] rb,
  output logic [DW-1:0] qa,
  output logic [DW-1:0] qb
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the min-heap timer queue. Commands go in through the start
// and busy handshake from a queue, with random gaps between them. A software
// heap works out the results of each command, and every out_valid beat is
// checked against them in order.
// ----------------------------------------------------------------------------
module tb;
  import mhtq_pkg::*;

  typedef struct packed {
    logic [2:0]       op;
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] amount;
    logic [EXP_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] expiry;
    logic             last;
  } res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       in_opcode = '0;
  logic [ID_W-1:0]  in_timer_id_in = '0;
  logic [EXP_W-1:0] in_time_amount = '0;
  logic [EXP_W-1:0] in_now = '0;
  logic             out_valid;
  logic [2:0]       out_result_kind;
  logic [ID_W-1:0]  out_timer_id_out;
  logic [EXP_W-1:0] out_expiry_out;
  logic             out_last;

  min_heap_timer_queue_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_timer_id_in(in_timer_id_in),
    .in_time_amount(in_time_amount), .in_now(in_now),
    .out_valid(out_valid), .out_result_kind(out_result_kind),
    .out_timer_id_out(out_timer_id_out), .out_expiry_out(out_expiry_out),
    .out_last(out_last)
  );

  always #6 clk = ~clk;

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int   errors = 0;
  int   gap_left = 0;
  bit   feeding_done = 0;

  // software heap
  logic [EXP_W-1:0] h_exp[CAPACITY];
  logic [ID_W-1:0]  h_id[CAPACITY];
  int               h_cnt = 0;
  logic [ID_W-1:0]  id_ctr = '0;

  function automatic void swap_slots(int a, int b);
    logic [EXP_W-1:0] te;
    logic [ID_W-1:0]  ti;
    te = h_exp[a]; h_exp[a] = h_exp[b]; h_exp[b] = te;
    ti = h_id[a]; h_id[a] = h_id[b]; h_id[b] = ti;
  endfunction

  function automatic void heap_up(int p);
    int par;
    while (p > 0 && p < h_cnt) begin
      par = (p - 1) / 2;
      if (!(h_exp[p] < h_exp[par])) break;
      swap_slots(p, par);
      p = par;
    end
  endfunction

  function automatic void heap_down(int p);
    int c;
    while (p < h_cnt) begin
      c = 2 * p + 1;
      if (c >= h_cnt) break;
      if (c + 1 < h_cnt && h_exp[c + 1] < h_exp[c]) c++;
      if (h_exp[p] <= h_exp[c]) break;
      swap_slots(p, c);
      p = c;
    end
  endfunction

  function automatic int slot_of(logic [ID_W-1:0] id);
    for (int k = 0; k < h_cnt; k++)
      if (h_id[k] == id) return k;
    return h_cnt;
  endfunction

  function automatic void drop_slot(int p);
    if (p >= h_cnt) return;
    h_exp[p] = h_exp[h_cnt - 1];
    h_id[p] = h_id[h_cnt - 1];
    h_cnt--;
    if (p < h_cnt) begin
      heap_down(p);
      heap_up(p);
    end
  endfunction

  function automatic void push_res(logic [2:0] k, logic [ID_W-1:0] id, logic [EXP_W-1:0] e);
    res_t r;
    r = '{kind: k, id: id, expiry: e, last: 1'b0};
    expected_res = {expected_res, r};
  endfunction

  function automatic void predict_timers(cmd_t c);
    int n0, p;
    logic [EXP_W:0] sum;
    logic [EXP_W-1:0] e;
    n0 = expected_res.size();
    case (c.op)
      OP_ADD: begin
        if (h_cnt >= CAPACITY) push_res(K_FULL, '0, '0);
        else begin
          sum = {1'b0, c.now} + {1'b0, c.amount};
          e = sum[EXP_W] ? '1 : sum[EXP_W-1:0];
          id_ctr++;
          h_exp[h_cnt] = e;
          h_id[h_cnt] = id_ctr;
          h_cnt++;
          heap_up(h_cnt - 1);
          push_res(K_ADDED, id_ctr, e);
        end
      end
      OP_DEL, OP_FIRE, OP_ADJ: begin
        p = slot_of(c.id);
        if (p >= h_cnt) push_res(K_NOTFOUND, c.id, '0);
        else if (c.op == OP_ADJ) begin
          h_exp[p] = c.amount;
          push_res(K_ADJUSTED, c.id, c.amount);
          heap_up(p);
          heap_down(slot_of(c.id));
        end else begin
          e = h_exp[p];
          drop_slot(p);
          push_res(c.op == OP_DEL ? K_DELETED : K_FIRED, c.id, e);
        end
      end
      OP_TICK: begin
        while (expected_res.size() - n0 < MAX_RESULTS && h_cnt > 0 && h_exp[0] <= c.now) begin
          push_res(K_FIRED, h_id[0], h_exp[0]);
          drop_slot(0);
        end
        if (expected_res.size() == n0) push_res(K_NONEDUE, '0, '0);
      end
      default: ;
    endcase
    if (expected_res.size() > n0) expected_res[expected_res.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  cmd_t cur;
  int   n_sent = 0;
  int   n_taken = 0;

  // accept bookkeeping
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_timers(cur);
      n_taken <= n_taken + 1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (n_sent != n_taken) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur = pending_cmds.pop_front();
        n_sent <= n_sent + 1;
        in_opcode <= cur.op;
        in_timer_id_in <= cur.id;
        in_time_amount <= cur.amount;
        in_now <= cur.now;
        start <= 1'b1;
        gap_left <= rand_gap();
      end else begin
        start <= 1'b0;
        feeding_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid) begin
      if (expected_res.size() == 0) report_mismatch("result with none expected");
      else begin
        e = expected_res.pop_front();
        if (out_result_kind !== e.kind)
          report_mismatch($sformatf("kind %0d exp %0d", out_result_kind, e.kind));
        if (out_timer_id_out !== e.id)
          report_mismatch($sformatf("id %0h exp %0h", out_timer_id_out, e.id));
        if (out_expiry_out !== e.expiry)
          report_mismatch($sformatf("expiry %0h exp %0h", out_expiry_out, e.expiry));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %0b exp %0b", out_last, e.last));
      end
    end
  end

  // shadow of ids the stimulus believes live, to aim commands at real timers
  logic [ID_W-1:0] live_ids[$];
  logic [ID_W-1:0] id_sim = '0;

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && live_ids.size() > 0)
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
    if (r < 9) return id_sim - ID_W'($urandom_range(0, 40));
    return ID_W'($urandom);
  endfunction

  function automatic void add_cmd(logic [2:0] op, logic [ID_W-1:0] id,
                                  logic [EXP_W-1:0] amt, logic [EXP_W-1:0] nw);
    cmd_t c;
    c = '{op: op, id: id, amount: amt, now: nw};
    pending_cmds = {pending_cmds, c};
    if (op == OP_ADD && live_ids.size() < CAPACITY) begin
      id_sim++;
      live_ids = {live_ids, id_sim};
    end
  endfunction

  initial begin
    logic [EXP_W-1:0] t;
    int r;
    for (int k = 0; k < CAPACITY; k++) begin
      h_exp[k] = '0;
      h_id[k] = '0;
    end
    // directed part
    add_cmd(OP_TICK, '0, '0, '0);
    add_cmd(OP_ADD, '0, '0, '0);
    add_cmd(OP_ADD, '0, '1, 32'h10);
    add_cmd(OP_ADD, '0, 32'h5, '1);
    add_cmd(OP_ADD, '0, 32'h7, 32'h3);
    add_cmd(OP_DEL, 16'd2, '0, '0);
    add_cmd(OP_FIRE, 16'd3, '0, '0);
    add_cmd(OP_ADJ, 16'd4, 32'h1, '0);
    add_cmd(OP_DEL, '1, '1, '1);
    add_cmd(OP_FIRE, 16'h5555, '0, '0);
    add_cmd(OP_ADJ, 16'hAAAA, 32'hAAAA_5555, '0);
    add_cmd(3'd5, '1, '1, '1);
    add_cmd(3'd7, '0, '0, '0);
    add_cmd(OP_TICK, '0, '0, 32'h0);
    add_cmd(OP_TICK, '0, '0, '1);
    for (int k = 0; k < CAPACITY + 2; k++) add_cmd(OP_ADD, '0, k % 5, 32'h100);
    add_cmd(OP_TICK, '0, '0, '1);
    add_cmd(OP_TICK, '0, '0, '1);
    live_ids.delete();
    // random part: add-heavy bursts with ticks walking time forward
    t = 32'h1000;
    for (int k = 0; k < 267; k++) begin
      r = $urandom_range(0, 99);
      if (k == 200) t = 32'hFFFF_FF00;
      if (r < 40) add_cmd(OP_ADD, ID_W'($urandom), $urandom_range(0, 60), t);
      else if (r < 50) add_cmd(OP_DEL, pick_id(), $urandom, $urandom);
      else if (r < 60) add_cmd(OP_FIRE, pick_id(), $urandom, $urandom);
      else if (r < 72) add_cmd(OP_ADJ, pick_id(), t + $urandom_range(0, 80), $urandom);
      else if (r < 96) begin
        t = t + $urandom_range(0, 30);
        add_cmd(OP_TICK, ID_W'($urandom), $urandom, t);
        live_ids.delete();
      end else if (r < 98) add_cmd(OP_ADD, ID_W'($urandom), $urandom, $urandom);
      else add_cmd(3'($urandom_range(5, 7)), ID_W'($urandom), $urandom, $urandom);
      if (r >= 50 && r < 60 && live_ids.size() > 0) void'(live_ids.pop_front());
    end
    add_cmd(OP_TICK, '0, '0, '1);
    add_cmd(OP_TICK, '0, '0, '1);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (feeding_done && n_sent == n_taken && expected_res.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
